// File: rtl/quaternion_inverse_rotate_top_assert.svh
// Assertion macros for the quaternion inverse rotation block
`ifndef QUATERNION_INVERSE_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_INVERSE_ROTATE_TOP_ASSERT_SVH

// check that cons holds whenever ante holds, outside reset
`define QIR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion inverse rotate check failed");

// check that cond never holds, outside reset
`define QIR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("quaternion inverse rotate check failed");

`endif

// File: rtl/qir_pkg.sv
// Shared widths, pipeline depths and types for the quaternion inverse rotation block
package qir_pkg;

  localparam int QW         = 16;          // quaternion component width
  localparam int VW         = 16;          // vector component width
  localparam int RW         = 17;          // rotated component width
  localparam int NSQ_W      = 33;          // squared norm width
  localparam int NORM_SHIFT = 30;          // squared norm is scaled by 2^30 before sqrt
  localparam int ROOT_W     = 32;          // integer square root width
  localparam int NUM_W      = 64;          // dividend width
  localparam int QUOT_W     = 32;          // quotient width
  localparam int NRM_W      = 33;          // signed unit component, Q30
  localparam int SQRT_STAGES = ROOT_W;     // one root bit per stage
  localparam int DIV_STAGES  = QUOT_W;     // one quotient bit per stage

  localparam logic [15:0] EPS_RESET = 16'd268;

  // sideband that travels with every item down the pipeline
  typedef struct packed {
    logic                   valid;
    logic                   ident;
    logic [3:0][QW-1:0]     q;     // w, x, y, z
    logic [2:0][VW-1:0]     v;     // x, y, z
  } side_t;

endpackage

// File: rtl/qir_sqrt.sv
// Pipelined integer square root of the scaled squared norm, one root bit per stage
module qir_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qir_pkg::NSQ_W-1:0]     nsq,
  output logic [qir_pkg::ROOT_W-1:0]    root
);

  localparam int STAGES = qir_pkg::SQRT_STAGES;
  localparam int RW     = qir_pkg::ROOT_W + 3;

  logic [RW-1:0]                 rem [0:STAGES-1];
  logic [qir_pkg::ROOT_W-1:0]    rt  [0:STAGES];
  logic [qir_pkg::NUM_W-1:0]     xs  [0:STAGES-1];

  // seed: radicand is nsq * 2^30
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign xs[0]  = {1'b0, nsq, {qir_pkg::NORM_SHIFT{1'b0}}};

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          fit;

    // bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem[k][RW-3:0], xs[k][qir_pkg::NUM_W-1 -: 2]};
    assign trial  = {1'b0, rt[k], 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k+1] <= {rt[k][qir_pkg::ROOT_W-2:0], fit};
      end
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fit ? (rem_sh - trial) : rem_sh;
          xs[k+1]  <= {xs[k][qir_pkg::NUM_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = rt[STAGES];

endmodule

// File: rtl/qir_div.sv
// Pipelined restoring divider, one quotient bit per stage
module qir_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qir_pkg::NUM_W-1:0]     numer,
  input  logic [qir_pkg::ROOT_W-1:0]    denom,
  output logic [qir_pkg::QUOT_W-1:0]    quot
);

  localparam int STAGES = qir_pkg::DIV_STAGES;
  localparam int DW     = qir_pkg::ROOT_W;
  localparam int LW     = qir_pkg::NUM_W - DW;

  logic [DW-1:0]                 rem [0:STAGES-1];
  logic [LW-1:0]                 nb  [0:STAGES-1];
  logic [DW-1:0]                 dn  [0:STAGES-1];
  logic [qir_pkg::QUOT_W-1:0]    qt  [0:STAGES];

  // upper half is already below the divisor, so it seeds the remainder
  assign rem[0] = numer[qir_pkg::NUM_W-1 -: DW];
  assign nb[0]  = numer[LW-1:0];
  assign dn[0]  = denom;
  assign qt[0]  = '0;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        fit;

    // shift in one dividend bit and subtract when the divisor fits
    assign rem_sh = {rem[k], nb[k][LW-1]};
    assign diff   = rem_sh - {1'b0, dn[k]};
    assign fit    = rem_sh >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        qt[k+1] <= {qt[k][qir_pkg::QUOT_W-2:0], fit};
      end
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fit ? diff[DW-1:0] : rem_sh[DW-1:0];
          nb[k+1]  <= {nb[k][LW-2:0], 1'b0};
          dn[k+1]  <= dn[k];
        end
      end
    end
  end

  assign quot = qt[STAGES];

endmodule

// File: rtl/quaternion_inverse_rotate_top.sv
// Top level: normalizes a quaternion and rotates a vector by its inverse
//
// Rotates a Q3.12 vector by the inverse of a Q1.14 quaternion and returns a
// saturated Q4.12 result. The quaternion is normalized first (square root
// and four divisions); a squared norm at or below norm_sq_epsilon selects
// the identity and sets tuser. After the squares and the norm sum, an item
// passes 32 stages of the bit-serial square root, the dividend stage, 32
// stages of the four parallel dividers and then the multiplier stages. A
// new item is accepted every cycle; the whole pipeline holds while a result
// waits on m_tready.
module quaternion_inverse_rotate_top (
  input  logic          clk,
  input  logic          rst,
  // configuration: norm_sq_epsilon
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  // input requests
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [111:0]  s_tdata,   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  // result requests
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [55:0]   m_tdata,   // rot_x, rot_y, rot_z, zero fill
  output logic          m_tuser    // used_identity
);

  localparam int ST_NSQ  = 2;
  localparam int ST_ROOT = ST_NSQ + qir_pkg::SQRT_STAGES;
  localparam int ST_NUM  = ST_ROOT + 1;
  localparam int ST_QUOT = ST_NUM + qir_pkg::DIV_STAGES;
  localparam int ST_UNIT = ST_QUOT + 1;
  localparam int ST_PROD = ST_UNIT + 1;
  localparam int ST_RND  = ST_PROD + 1;
  localparam int ST_MUL  = ST_RND + 1;
  localparam int ST_SUM  = ST_MUL + 1;
  localparam int ST_OUT  = ST_SUM + 1;

  localparam int NW = qir_pkg::NRM_W;
  localparam logic signed [NW-1:0] UNIT_Q30 = NW'(1) <<< 30;

  logic                          adv;
  logic [15:0]                   eps;
  qir_pkg::side_t                sd     [0:ST_OUT];
  qir_pkg::side_t                sd_fwd [0:ST_OUT-1];

  logic [30:0]                   sq    [0:3];
  logic [qir_pkg::NSQ_W-1:0]     nsq;
  logic [qir_pkg::ROOT_W-1:0]    root;
  logic [qir_pkg::NUM_W-1:0]     numer [0:3];
  logic [qir_pkg::ROOT_W-1:0]    den;
  logic [qir_pkg::QUOT_W-1:0]    quot  [0:3];
  logic signed [NW-1:0]          nrm   [0:3];
  logic signed [NW-1:0]          nrm_p [0:3];
  logic signed [NW-1:0]          nrm_r [0:3];

  logic signed [65:0]            nwsq;
  logic signed [48:0]            pc    [0:5];
  logic signed [48:0]            pd    [0:2];
  logic signed [34:0]            cf;
  logic signed [35:0]            crr   [0:2];
  logic signed [36:0]            dotr;
  logic signed [50:0]            av    [0:2];
  logic signed [68:0]            bp    [0:2];
  logic signed [69:0]            dp    [0:2];
  logic signed [71:0]            as    [0:2];
  logic signed [71:0]            dmb   [0:2];
  logic [qir_pkg::RW-1:0]        rot   [0:2];

  // advance everything unless a result is held at the output
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= qir_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      eps <= cfg_data;
    end
  end

  // take a request into the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (adv) begin
      sd[0].valid <= s_tvalid;
      sd[0].ident <= 1'b0;
      sd[0].q     <= s_tdata[63:0];
      sd[0].v     <= s_tdata[111:64];
    end
  end

  // sideband line; the identity decision joins it after the norm stage
  for (genvar j = 0; j < ST_OUT; j++) begin : g_side
    if (j == ST_NSQ) begin : g_ident
      always_comb begin
        sd_fwd[j]       = sd[j];
        sd_fwd[j].ident = nsq <= {{(qir_pkg::NSQ_W-16){1'b0}}, eps};
      end
    end else begin : g_pass
      assign sd_fwd[j] = sd[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[j+1].valid <= 1'b0;
      end else if (adv) begin
        sd[j+1] <= sd_fwd[j];
      end
    end
  end

  // squares of the components
  for (genvar i = 0; i < 4; i++) begin : g_sq
    logic signed [31:0] sqp;
    assign sqp = $signed(sd[0].q[i]) * $signed(sd[0].q[i]);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[i] <= sqp[30:0];
      end
    end
  end

  // squared norm
  always_ff @(posedge clk) begin
    if (adv) begin
      nsq <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]} + {2'b00, sq[3]};
    end
  end

  qir_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .nsq  (nsq),
    .root (root)
  );

  // dividends |q| * 2^45 + root/2 for rounded division
  for (genvar i = 0; i < 4; i++) begin : g_num
    logic [15:0] mag;
    assign mag = sd[ST_ROOT].q[i][15] ? (~sd[ST_ROOT].q[i] + 16'd1) : sd[ST_ROOT].q[i];
    always_ff @(posedge clk) begin
      if (adv) begin
        numer[i] <= {3'b000, mag, 45'd0} + {33'd0, root[qir_pkg::ROOT_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den <= root;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    qir_div u_div (
      .clk   (clk),
      .en    (adv),
      .numer (numer[i]),
      .denom (den),
      .quot  (quot[i])
    );

    // restore the sign, or substitute the identity
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sd[ST_QUOT].ident) begin
          nrm[i] <= (i == 0) ? UNIT_Q30 : '0;
        end else if (sd[ST_QUOT].q[i][15]) begin
          nrm[i] <= -$signed({1'b0, quot[i]});
        end else begin
          nrm[i] <= $signed({1'b0, quot[i]});
        end
        nrm_p[i] <= nrm[i];
        nrm_r[i] <= nrm_p[i];
      end
    end
  end

  // square of the scalar part and products of the vector part with the vector
  always_ff @(posedge clk) begin
    if (adv) begin
      nwsq  <= nrm[0] * nrm[0];
      pc[0] <= nrm[2] * $signed(sd[ST_UNIT].v[2]);
      pc[1] <= nrm[3] * $signed(sd[ST_UNIT].v[1]);
      pc[2] <= nrm[3] * $signed(sd[ST_UNIT].v[0]);
      pc[3] <= nrm[1] * $signed(sd[ST_UNIT].v[2]);
      pc[4] <= nrm[1] * $signed(sd[ST_UNIT].v[1]);
      pc[5] <= nrm[2] * $signed(sd[ST_UNIT].v[0]);
      pd[0] <= nrm[1] * $signed(sd[ST_UNIT].v[0]);
      pd[1] <= nrm[2] * $signed(sd[ST_UNIT].v[1]);
      pd[2] <= nrm[3] * $signed(sd[ST_UNIT].v[2]);
    end
  end

  // 2w^2 - 1 rounded to Q30, cross product and dot product rounded to Q28
  logic signed [65:0] cf_full;
  logic signed [49:0] cr    [0:2];
  logic signed [49:0] crs   [0:2];
  logic signed [50:0] dot;
  logic signed [50:0] dots;

  assign cf_full = (((nwsq <<< 1) + 66'sd536870912) >>> 30) - 66'sd1073741824;
  assign cr[0]   = 50'(pc[0]) - 50'(pc[1]);
  assign cr[1]   = 50'(pc[2]) - 50'(pc[3]);
  assign cr[2]   = 50'(pc[4]) - 50'(pc[5]);
  assign dot     = 51'(pd[0]) + 51'(pd[1]) + 51'(pd[2]);
  assign dots    = (dot + 51'sd8192) >>> 14;

  for (genvar i = 0; i < 3; i++) begin : g_crs
    assign crs[i] = (cr[i] + 50'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cf     <= cf_full[34:0];
      crr[0] <= crs[0][35:0];
      crr[1] <= crs[1][35:0];
      crr[2] <= crs[2][35:0];
      dotr   <= dots[36:0];
    end
  end

  // scale the vector, the cross term and the dot term
  for (genvar i = 0; i < 3; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (adv) begin
        av[i] <= $signed(sd[ST_RND].v[i]) * cf;
        bp[i] <= nrm_r[0] * crr[i];
        dp[i] <= nrm_r[i+1] * dotr;
      end
    end
  end

  // round the cross and dot terms and combine them
  for (genvar i = 0; i < 3; i++) begin : g_bd
    logic signed [71:0] bq;
    logic signed [71:0] dq;
    assign bq = (72'(bp[i]) + 72'sd16384) >>> 15;
    assign dq = (72'(dp[i]) + 72'sd16384) >>> 15;
    always_ff @(posedge clk) begin
      if (adv) begin
        as[i]  <= 72'(av[i]);
        dmb[i] <= dq - bq;
      end
    end
  end

  // final rounding and saturation into the output register
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic signed [71:0] rs;
    assign rs = (as[i] + dmb[i] + 72'sd536870912) >>> 30;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rs > 72'sd65535) begin
          rot[i] <= 17'h0FFFF;
        end else if (rs < -72'sd65536) begin
          rot[i] <= 17'h10000;
        end else begin
          rot[i] <= rs[16:0];
        end
      end
    end
  end

  assign m_tvalid = sd[ST_OUT].valid;
  assign m_tuser  = sd[ST_OUT].ident;
  assign m_tdata  = {5'd0, rot[2], rot[1], rot[0]};

`include "quaternion_inverse_rotate_top_assert.svh"

  // a real norm always yields a nonzero root
  `QIR_ASSERT_NEVER(a_root_nonzero, sd[ST_ROOT].valid && !sd[ST_ROOT].ident && root == '0)
  // unit components never reach 2^31
  `QIR_ASSERT_IMPL(a_unit_bound, sd[ST_QUOT].valid && !sd[ST_QUOT].ident, !quot[0][31] && !quot[1][31] && !quot[2][31] && !quot[3][31])
  // identity fallback passes the vector through unchanged
  `QIR_ASSERT_IMPL(a_ident_pass, m_tvalid && m_tuser, rot[0] == {sd[ST_OUT].v[0][15], sd[ST_OUT].v[0]} && rot[1] == {sd[ST_OUT].v[1][15], sd[ST_OUT].v[1]} && rot[2] == {sd[ST_OUT].v[2][15], sd[ST_OUT].v[2]})

endmodule
